### rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/gcrdec_pkg.sv
package gcrdec_pkg;

    localparam int DELTA_WIDTH_DEF = 16;
    localparam int CELL_W          = 13;
    localparam int ZCNT_W          = 6;

    localparam logic [CELL_W-1:0] CELL_SLOW_NS   = 13'd3200;
    localparam logic [CELL_W-1:0] CELL_FAST_NS   = 13'd2000;
    localparam logic [CELL_W-1:0] NOISE_SLOW_NS  = 13'(3200 * 3 / 4);
    localparam logic [CELL_W-1:0] NOISE_FAST_NS  = 13'(2000 * 3 / 4);
    localparam logic [ZCNT_W-1:0] ZERO_RUN_CAP   = 6'd40;
    localparam logic [31:0]       GCR_VALID_MASK = 32'h6EEC_EE00;

    localparam logic [3:0] WIN_LAST = 4'd9;

    // Strobes from the sequencer to the bit window
    typedef struct packed {
        logic clear;
        logic push;
        logic bit_val;
    } win_ctl_t;

    // Window response for the bit being pushed this cycle
    typedef struct packed {
        logic       emit;
        logic [7:0] byte_val;
    } win_res_t;

    // Strobes from the sequencer to the interval counter
    typedef struct packed {
        logic load;
        logic advance;
    } ivl_ctl_t;

    function automatic logic [3:0] gcr_nibble(input logic [4:0] code);
        logic [3:0] n;
        case (code)
            5'd9:    n = 4'd8;
            5'd11:   n = 4'd1;
            5'd13:   n = 4'd12;
            5'd14:   n = 4'd4;
            5'd15:   n = 4'd5;
            5'd18:   n = 4'd2;
            5'd19:   n = 4'd3;
            5'd21:   n = 4'd15;
            5'd22:   n = 4'd6;
            5'd23:   n = 4'd7;
            5'd25:   n = 4'd9;
            5'd26:   n = 4'd10;
            5'd27:   n = 4'd11;
            5'd29:   n = 4'd13;
            5'd30:   n = 4'd14;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

### rtl/gcrdec_interval.sv
module gcrdec_interval
    import gcrdec_pkg::*;
#(
    parameter int DELTA_WIDTH = DELTA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ivl_ctl_t               ctl,
    input  logic [DELTA_WIDTH-1:0] delta,
    input  logic [CELL_W-1:0]      cell_len,
    output logic                   final_bit
);

    logic [DELTA_WIDTH-1:0] rem_reg, rem_next;
    logic [ZCNT_W-1:0]      zcnt_reg, zcnt_next;
    logic [DELTA_WIDTH:0]   two_cells;

    assign two_cells = {(DELTA_WIDTH + 1 - CELL_W)'(0), cell_len} << 1;

    // Last bit of the run once less than two cells remain or the zero run is capped
    assign final_bit = ({1'b0, rem_reg} < two_cells) || (zcnt_reg == ZERO_RUN_CAP);

    always_comb
    begin
        rem_next  = rem_reg;
        zcnt_next = zcnt_reg;
        if (ctl.load)
        begin
            rem_next  = delta;
            zcnt_next = '0;
        end
        else if (ctl.advance && !final_bit)
        begin
            rem_next  = rem_reg - DELTA_WIDTH'(cell_len);
            zcnt_next = zcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            zcnt_reg <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            zcnt_reg <= zcnt_next;
        end
    end

endmodule

### rtl/gcrdec_window.sv
module gcrdec_window
    import gcrdec_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  win_ctl_t ctl,
    output win_res_t res
);

    logic [9:0] win_reg, win_next;
    logic [3:0] fill_reg, fill_next;
    logic [9:0] shifted;
    logic       hi_ok, lo_ok;

    assign shifted = {win_reg[8:0], ctl.bit_val};
    assign hi_ok   = GCR_VALID_MASK[shifted[9:5]];
    assign lo_ok   = GCR_VALID_MASK[shifted[4:0]];

    assign res.emit     = ctl.push && (fill_reg == WIN_LAST) && hi_ok && lo_ok;
    assign res.byte_val = {gcr_nibble(shifted[9:5]), gcr_nibble(shifted[4:0])};

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (ctl.clear)
        begin
            win_next  = '0;
            fill_next = '0;
        end
        else if (ctl.push)
        begin
            if (fill_reg != WIN_LAST)
            begin
                win_next  = shifted;
                fill_next = fill_reg + 1'b1;
            end
            else if (hi_ok && lo_ok)
            begin
                win_next  = '0;
                fill_next = '0;
            end
            else
            begin
                // bit slip: drop the oldest bit
                win_next  = {1'b0, shifted[8:0]};
                fill_next = WIN_LAST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
        end
    end

endmodule

### rtl/gcr_flux_to_nibble_decoder_unit.sv
// Flux interval to GCR byte decoder. Each accepted interval is turned into a run of
// floor(interval / cell) - 1 zero bits (none for short intervals, at most 40) and a
// closing one bit; intervals under three quarters of a cell are dropped as noise.
// The bits are shifted into a 10-bit window by a subtract-and-compare interval
// counter, one per clock unless a pending byte is held back by the output stall.
// An item is accepted, shifted bit by bit and flushed, and in_stall holds off the
// next one until the FSM is idle again; noise is only accepted. Up to two bytes come
// out per interval; last_of_run marks the final one. cell_mode selects a 3200 ns or
// 2000 ns cell and may be written only while no transaction is in flight.
`include "assert_macros.svh"

module gcr_flux_to_nibble_decoder_unit
    import gcrdec_pkg::*;
#(
    parameter int DELTA_WIDTH = DELTA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [DELTA_WIDTH-1:0] flux_delta_ns,
    input  logic                   start_of_track,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             data_byte,
    output logic                   last_of_run,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_FLUSH
    } state_t;

    state_t     state_reg;
    logic       cell_mode_reg;
    logic       pend_valid_reg;
    logic [7:0] pend_byte_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              step;
    logic              final_bit;
    logic [CELL_W-1:0] cell_len;
    logic [CELL_W-1:0] noise_lim;
    logic              is_noise;
    win_ctl_t          wctl;
    win_res_t          wres;
    ivl_ctl_t          ictl;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign data_byte   = out_byte_reg;
    assign last_of_run = out_last_reg;

    assign cell_len  = cell_mode_reg ? CELL_FAST_NS : CELL_SLOW_NS;
    assign noise_lim = cell_mode_reg ? NOISE_FAST_NS : NOISE_SLOW_NS;
    assign is_noise  = flux_delta_ns < DELTA_WIDTH'(noise_lim);

    assign out_free = !out_valid_reg || !out_stall;
    // Hold the shifter while a pending byte could not be moved out
    assign step     = (state_reg == ST_SHIFT) && (!pend_valid_reg || out_free);
    assign out_load = (step && wres.emit && pend_valid_reg)
                   || ((state_reg == ST_FLUSH) && pend_valid_reg && out_free);

    assign wctl.clear   = in_accept && start_of_track;
    assign wctl.push    = step;
    assign wctl.bit_val = final_bit;

    assign ictl.load    = in_accept;
    assign ictl.advance = step;

    gcrdec_interval #(
        .DELTA_WIDTH(DELTA_WIDTH)
    ) u_interval (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ictl),
        .delta    (flux_delta_ns),
        .cell_len (cell_len),
        .final_bit(final_bit)
    );

    gcrdec_window u_window (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (wctl),
        .res  (wres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cell_mode_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_byte_reg  <= '0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cell_mode_reg <= cfg_data;
            end

            // raise on a new output transaction, drop it once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && !is_noise)
                    begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT:
                begin
                    if (step)
                    begin
                        if (wres.emit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_byte_reg <= pend_byte_reg;
                                out_last_reg <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_byte_reg  <= wres.byte_val;
                        end
                        if (final_bit)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_byte_reg   <= pend_byte_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_SAME(a_no_pend_idle, state_reg == ST_IDLE, !pend_valid_reg)
    `ASSERT_SAME(a_emit_has_slot, step && wres.emit && pend_valid_reg, out_free)
    `ASSERT_NEXT(a_flush_done, state_reg == ST_FLUSH && !pend_valid_reg, state_reg == ST_IDLE)

endmodule

### tb/tb_gcr_flux_to_nibble_decoder_unit.sv
`timescale 1ns / 1ps

module tb_gcr_flux_to_nibble_decoder_unit
    import gcrdec_pkg::*;
;

    localparam logic MODE_SLOW = 1'b0;
    localparam logic MODE_FAST = 1'b1;
    localparam int MAX_BYTES_PER_IVL = 4;
    localparam int SETTLE_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT = 300000;

    // Group code per nibble value, index = nibble
    localparam logic [4:0] NIBBLE_CODE [16] = '{
        5'd10, 5'd11, 5'd18, 5'd19, 5'd14, 5'd15, 5'd22, 5'd23,
        5'd9,  5'd25, 5'd26, 5'd27, 5'd13, 5'd29, 5'd30, 5'd21
    };

    typedef enum int {MUT_NONE, MUT_FLIP, MUT_SLIP, MUT_NO_SYNC} mutation_t;

    typedef struct packed {
        logic [15:0] delta;
        logic        sot;
    } flux_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } gcr_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] flux_delta_ns = '0;
    logic        start_of_track = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  data_byte;
    logic        last_of_run;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    // Decoder state mirror
    logic        cell_sel = MODE_SLOW;
    logic [9:0]  win_bits = '0;
    logic [3:0]  win_fill = '0;

    flux_item_t  flux_q[$];
    gcr_byte_t   decoded_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned decoding_items = 0;
    int unsigned noise_cnt = 0;
    int unsigned bytes_seen = 0;
    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;

    gcr_flux_to_nibble_decoder_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .flux_delta_ns  (flux_delta_ns),
        .start_of_track (start_of_track),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data_byte      (data_byte),
        .last_of_run    (last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned cell_ns();
        return (cell_sel == MODE_FAST) ? int'(CELL_FAST_NS) : int'(CELL_SLOW_NS);
    endfunction

    // {valid, nibble} for one 5-bit group
    function automatic logic [4:0] gcr_group(input logic [4:0] code);
        for (int k = 0; k < 16; k++)
        begin
            if (NIBBLE_CODE[k] == code)
                return {1'b1, 4'(k)};
        end
        return 5'b0;
    endfunction

    function automatic void decode_interval(input logic [15:0] delta, input logic sot);
        int unsigned cell_len;
        int unsigned zeros;
        int unsigned n;
        logic [4:0]  hi;
        logic [4:0]  lo;
        gcr_byte_t   held;
        bit          have;
        cell_len = cell_ns();
        n = 0;
        have = 1'b0;
        held = '0;
        if (sot)
        begin
            win_bits = '0;
            win_fill = '0;
        end
        if (delta < cell_len * 3 / 4)
        begin
            noise_cnt++;
            return;
        end
        zeros = delta / cell_len;
        zeros = (zeros >= 1) ? zeros - 1 : 0;
        if (zeros > ZERO_RUN_CAP)
            zeros = ZERO_RUN_CAP;
        for (int unsigned i = 0; i <= zeros; i++)
        begin
            win_bits = {win_bits[8:0], 1'(i == zeros)};
            win_fill = win_fill + 4'd1;
            if (win_fill == 4'd10)
            begin
                hi = gcr_group(win_bits[9:5]);
                lo = gcr_group(win_bits[4:0]);
                if (hi[4] && lo[4])
                begin
                    if (n < MAX_BYTES_PER_IVL)
                    begin
                        if (have)
                            decoded_q.push_back(held);
                        held.data = {hi[3:0], lo[3:0]};
                        held.last = 1'b0;
                        have = 1'b1;
                        n++;
                    end
                    win_bits = '0;
                    win_fill = '0;
                end
                else
                begin
                    // bit slip: drop the oldest bit
                    win_bits[9] = 1'b0;
                    win_fill = 4'd9;
                end
            end
        end
        if (have)
        begin
            held.last = 1'b1;
            decoded_q.push_back(held);
        end
    endfunction

    function automatic void add_item(input logic [15:0] delta, input logic sot);
        flux_item_t it;
        it.delta = delta;
        it.sot = sot;
        flux_q.push_back(it);
        items_queued++;
        if (delta >= cell_ns() * 3 / 4)
            decoding_items++;
    endfunction

    // Interval that yields exactly the given number of zeros and then a one
    function automatic logic [15:0] run_delta(input int unsigned zeros);
        int unsigned cell_len;
        int unsigned lo;
        int unsigned hi;
        cell_len = cell_ns();
        lo = (zeros == 0) ? cell_len * 3 / 4 : (zeros + 1) * cell_len;
        hi = (zeros + 2) * cell_len - 1;
        if (hi > 16'hFFFF)
            hi = 16'hFFFF;
        if (lo > hi)
            lo = hi;
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic void add_edges();
        int unsigned cell_len;
        cell_len = cell_ns();
        add_item(16'd0, 1'b1);
        add_item(16'(cell_len * 3 / 4 - 1), 1'b0);
        add_item(16'(cell_len * 3 / 4), 1'b0);
        add_item(16'(2 * cell_len - 1), 1'b0);
        add_item(16'(2 * cell_len), 1'b0);
        add_item(16'hFFFF, 1'b0);
    endfunction

    // Encode bytes as a group-coded bit stream, then as flux intervals
    function automatic void add_track(input logic [7:0] payload[$], input mutation_t how);
        bit          stream[$];
        logic [9:0]  pair;
        int unsigned zrun;
        int unsigned idx;
        logic        sot;
        sot = 1'b1;
        foreach (payload[j])
        begin
            pair = {NIBBLE_CODE[payload[j][7:4]], NIBBLE_CODE[payload[j][3:0]]};
            for (int b = 9; b >= 0; b--)
                stream.push_back(pair[b]);
        end
        // closing one flushes a trailing zero of the last group
        stream.push_back(1'b1);
        case (how)
            MUT_FLIP:
            begin
                idx = $urandom_range(stream.size() - 2);
                stream[idx] = !stream[idx];
            end
            MUT_SLIP:
            begin
                idx = $urandom_range(stream.size() - 1);
                stream.insert(idx, 1'($urandom_range(1)));
            end
            MUT_NO_SYNC: sot = 1'b0;
            default: ;
        endcase
        zrun = 0;
        foreach (stream[j])
        begin
            if (!stream[j])
                zrun++;
            else
            begin
                add_item(run_delta(zrun), sot);
                sot = 1'b0;
                zrun = 0;
                if ($urandom_range(9) == 0)
                    add_item(16'($urandom_range(cell_ns() * 3 / 4 - 1)), 1'b0);
            end
        end
    endfunction

    function automatic void fill_random(input int unsigned target);
        logic [7:0]  payload[$];
        int unsigned base;
        mutation_t   how;
        base = decoding_items;
        add_edges();
        while (decoding_items - base < target)
        begin
            if ($urandom_range(99) < 20)
                add_item(16'($urandom), 1'($urandom_range(1)));
            else
            begin
                payload = {};
                repeat ($urandom_range(4, 1))
                    payload.push_back(8'($urandom));
                how = MUT_NONE;
                if ($urandom_range(99) < 25)
                    how = mutation_t'($urandom_range(MUT_NO_SYNC, MUT_FLIP));
                add_track(payload, how);
            end
        end
    endfunction

    task automatic write_cell_mode(input logic mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cell_sel = mode;
        @(negedge clk);
    endtask

    task automatic drain();
        while (items_accepted != items_queued || decoded_q.size() != 0)
            @(posedge clk);
        // an interval that decodes nothing may still be shifting
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : flux_driver
        flux_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            flux_delta_ns <= '0;
            start_of_track <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_interval(flux_delta_ns, start_of_track);
                items_accepted++;
            end
            // hold a stalled transaction, otherwise offer the next one
            if (!in_valid || !in_stall)
            begin
                if (flux_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = flux_q.pop_front();
                    in_valid <= 1'b1;
                    flux_delta_ns <= nxt.delta;
                    start_of_track <= nxt.sot;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : byte_monitor
        gcr_byte_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected byte: data_byte 0x%02h, last_of_run %0b",
                           data_byte, last_of_run);
                    err_cnt++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    bytes_seen++;
                    if (data_byte !== want.data)
                    begin
                        $error("data_byte: expected 0x%02h, got 0x%02h", want.data, data_byte);
                        err_cnt++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                        err_cnt++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] payload[$];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 14;
        recv_idle_pct = 59;
        write_cell_mode(MODE_SLOW);
        add_edges();
        payload = '{8'h00, 8'hFF};
        add_track(payload, MUT_NONE);
        payload = '{8'h5A, 8'h3C};
        add_track(payload, MUT_SLIP);
        drain();

        write_cell_mode(MODE_FAST);
        fill_random(45);
        drain();

        send_idle_pct = 59;
        recv_idle_pct = 14;
        write_cell_mode(MODE_SLOW);
        fill_random(45);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cell_mode(MODE_FAST);
        fill_random(40);
        drain();

        $display("Run covered %0d flux intervals (%0d treated as noise) in both cell modes,",
                 items_accepted, noise_cnt);
        $display("with %0d decoded bytes checked under three back-pressure profiles.",
                 bytes_seen);
        if (err_cnt == 0 && decoded_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/gcrdec_pkg.sv
rtl/gcrdec_interval.sv
rtl/gcrdec_window.sv
rtl/gcr_flux_to_nibble_decoder_unit.sv
tb/tb_gcr_flux_to_nibble_decoder_unit.sv
